[rtl/defa_pkg.sv]
// shared types, opcodes and helper functions of the extended float alu
package defa_pkg;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MPY = 4'd2, CMD_NEG = 4'd3,
      CMD_ABS = 4'd4, CMD_NORM = 4'd5, CMD_RND = 4'd6, CMD_FLOAT = 4'd7,
      CMD_FIX = 4'd8, CMD_LDE = 4'd9, CMD_LDM = 4'd10, CMD_TOSGL = 4'd11
   } cmd_type;

   localparam logic [1:0] FORM_SHORT  = 2'd1;
   localparam logic [1:0] FORM_SINGLE = 2'd2;
   localparam logic signed [7:0] EXP_ZERO = -8'sd128;

   // stage 1 to stage 2 payload
   typedef struct packed {
      logic [3:0]  cmd;
      logic [1:0]  b_form;
      logic signed [9:0] ea;
      logic [31:0] ma;
      logic signed [9:0] eb;
      logic [31:0] mb;
      logic [31:0] b_raw;
   } opnd_type;

   // stage 2 to stage 3 payload: raw arithmetic before normalize
   typedef struct packed {
      logic [3:0]  cmd;
      logic signed [9:0] e;
      logic signed [34:0] c;
      logic [49:0] p;
      logic [31:0] m;
      logic [31:0] raw;
      logic        ov;
      logic        uf;
   } mid_type;

   typedef struct packed {
      logic signed [7:0] e;
      logic [31:0] m;
      logic        ov;
      logic        uf;
   } res_type;

   // leading zero count of a 32-bit word
   function automatic logic [5:0] clz32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   // 33-bit signed mantissa with implied bit
   function automatic logic signed [34:0] mant33(input logic [31:0] m);
      if (m[31]) return 35'(signed'({2'b11, 1'b0, m[30:0]}));
      return 35'(signed'({3'b001, m[30:0]}));
   endfunction

   function automatic logic [31:0] pack_man(input logic signed [34:0] c);
      return {c[32], c[30:0]};
   endfunction

endpackage

[rtl/dsp_extended_float_alu.sv]
// top level of the extended float alu: three-stage pipeline
//
// channel | dir | ports                                         | handshake
// req     | in  | cmd a_form a_exp a_man b_form b_exp b_man     | req_valid / req_stall
// rsp     | out | res_exp res_man overflow underflow            | rsp_valid / rsp_stall
//
// one transaction per cycle while rsp is not stalled; the steps are expand, align and add/multiply, normalize
// reset is synchronous and clears only the stage valid bits
// a stall on rsp holds the last stage; earlier stages keep moving into bubbles
module dsp_extended_float_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_cmd,
   input  logic [1:0]  req_a_form,
   input  logic signed [7:0] req_a_exp,
   input  logic [31:0] req_a_man,
   input  logic [1:0]  req_b_form,
   input  logic signed [7:0] req_b_exp,
   input  logic [31:0] req_b_man,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [7:0] rsp_res_exp,
   output logic [31:0] rsp_res_man,
   output logic        rsp_overflow,
   output logic        rsp_underflow
);
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   defa_pkg::opnd_type s1_ff, s1_in;
   defa_pkg::mid_type  s2_ff, s2_in;
   defa_pkg::res_type  s3_ff, s3_in;

   // stage enables: a stage moves when downstream is free
   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   logic signed [9:0] ea_x, eb_x;
   logic [31:0] ma_x, mb_x;

   defa_expand u_exp_a (.form(req_a_form), .exp_in(req_a_exp), .man_in(req_a_man),
                        .exp_out(ea_x), .man_out(ma_x));
   defa_expand u_exp_b (.form(req_b_form), .exp_in(req_b_exp), .man_in(req_b_man),
                        .exp_out(eb_x), .man_out(mb_x));

   always_comb begin
      s1_in.cmd = req_cmd;
      s1_in.b_form = req_b_form;
      s1_in.ea = ea_x;
      s1_in.ma = ma_x;
      s1_in.eb = eb_x;
      s1_in.mb = mb_x;
      s1_in.b_raw = req_b_man;
   end

   // ---------------- stage 2: align and add, or multiply
   logic signed [9:0] sa_e, sb_e, ediff;
   logic [31:0] sa_m, sb_m;
   logic sub_op, is_abs;
   logic signed [34:0] xa, xb, xa_sh, xb_sh;
   logic [5:0] shamt;
   logic signed [25:0] pa, pb;

   always_comb begin
      // neg and abs are 0 - A
      sub_op = 1'b0;
      is_abs = 1'b0;
      sa_e = s1_ff.ea; sa_m = s1_ff.ma;
      sb_e = s1_ff.eb; sb_m = s1_ff.mb;
      case (defa_pkg::cmd_type'(s1_ff.cmd))
         defa_pkg::CMD_SUB: sub_op = 1'b1;
         defa_pkg::CMD_NEG, defa_pkg::CMD_ABS: begin
            sub_op = 1'b1;
            is_abs = (defa_pkg::cmd_type'(s1_ff.cmd) == defa_pkg::CMD_ABS);
            sa_e = 10'(defa_pkg::EXP_ZERO); sa_m = '0;
            sb_e = s1_ff.ea; sb_m = s1_ff.ma;
         end
         default: ;
      endcase
      xa = (sa_e == 10'(defa_pkg::EXP_ZERO)) ? '0 : defa_pkg::mant33(sa_m);
      xb = (sb_e == 10'(defa_pkg::EXP_ZERO)) ? '0 : defa_pkg::mant33(sb_m);
      ediff = (sa_e <= sb_e) ? sb_e - sa_e : sa_e - sb_e;
      shamt = (ediff > 10'sd34) ? 6'd34 : ediff[5:0];
      xa_sh = xa; xb_sh = xb;
      if (sa_e <= sb_e) xa_sh = xa >>> shamt;
      else              xb_sh = xb >>> shamt;
      pa = (s1_ff.ea == 10'(defa_pkg::EXP_ZERO)) ? '0 : 26'(defa_pkg::mant33(s1_ff.ma) >>> 8);
      pb = (s1_ff.eb == 10'(defa_pkg::EXP_ZERO)) ? '0 : 26'(defa_pkg::mant33(s1_ff.mb) >>> 8);

      s2_in.cmd = s1_ff.cmd;
      s2_in.e = (sa_e <= sb_e) ? sb_e : sa_e;
      s2_in.c = sub_op ? xa_sh - xb_sh : xa_sh + xb_sh;
      s2_in.p = 50'(pa * pb);
      s2_in.m = s1_ff.ma;
      s2_in.raw = s1_ff.b_raw;
      s2_in.ov = is_abs;
      s2_in.uf = 1'b0;
      case (defa_pkg::cmd_type'(s1_ff.cmd))
         defa_pkg::CMD_MPY: s2_in.e = s1_ff.ea + s1_ff.eb;
         defa_pkg::CMD_ABS: begin
            // abs of zero or positive passes A
            s2_in.uf = (s1_ff.ea == 10'(defa_pkg::EXP_ZERO)) || !s1_ff.ma[31];
            s2_in.e = s1_ff.ea;
         end
         defa_pkg::CMD_LDE: begin
            s2_in.e = s1_ff.eb;
            s2_in.m = (s1_ff.eb == 10'(defa_pkg::EXP_ZERO)) ? '0 : s1_ff.ma;
         end
         defa_pkg::CMD_LDM: begin
            s2_in.e = s1_ff.ea;
            s2_in.m = (s1_ff.b_form == defa_pkg::FORM_SINGLE) ? s1_ff.b_raw : s1_ff.mb;
         end
         defa_pkg::CMD_NORM, defa_pkg::CMD_RND, defa_pkg::CMD_FIX,
         defa_pkg::CMD_TOSGL: s2_in.e = s1_ff.ea;
         default: if (s1_ff.cmd > 4'(defa_pkg::CMD_TOSGL)) s2_in.e = s1_ff.ea;
      endcase
   end

   // ---------------- stage 3: normalize, round, fix, saturate
   logic signed [34:0] c, cn, t, rc;
   logic [5:0] n;
   logic [31:0] nv, m, u;
   logic signed [10:0] ex;
   logic [1:0] s;
   logic signed [49:0] p;

   always_comb begin
      c = s2_ff.c; m = s2_ff.m; p = s2_ff.p;
      ex = 11'(s2_ff.e);
      s3_in.e = s2_ff.e[7:0];
      s3_in.m = m;
      s3_in.ov = 1'b0;
      s3_in.uf = 1'b0;
      n = '0; nv = '0; cn = c; t = '0; rc = '0; s = '0; u = '0;
      case (defa_pkg::cmd_type'(s2_ff.cmd))
         defa_pkg::CMD_ADD, defa_pkg::CMD_SUB, defa_pkg::CMD_NEG, defa_pkg::CMD_ABS: begin
            if (defa_pkg::cmd_type'(s2_ff.cmd) == defa_pkg::CMD_ABS && s2_ff.uf) begin
               s3_in.m = (s2_ff.e == 10'(defa_pkg::EXP_ZERO)) ? '0 : m;
            end else begin
               if (c == 0) begin
                  ex = 11'(defa_pkg::EXP_ZERO);
               end else if (c >= 35'sh1_0000_0000 || c < -35'sh1_0000_0000) begin
                  cn = c >>> 1;
                  ex = ex + 11'sd1;
               end else if ((c > 0 && c < 35'sh8000_0000) ||
                            (c < 0 && c >= -35'sh8000_0000)) begin
                  nv = c[31:0] ^ {32{c[34]}};
                  n = defa_pkg::clz32(nv);
                  cn = c <<< n;
                  ex = ex - 11'(n);
               end
               if (ex > 11'sd127) begin
                  s3_in.ov = 1'b1; ex = 11'sd127;
                  cn = cn > 0 ? 35'sh0_FFFF_FFFF : -35'sh1_0000_0000;
               end else if (ex < -11'sd128) begin
                  s3_in.uf = !s2_ff.ov; ex = -11'sd128; cn = '0;
               end
               s3_in.e = ex[7:0];
               s3_in.m = defa_pkg::pack_man(cn);
            end
         end
         defa_pkg::CMD_MPY: begin
            t = 35'(p >>> 46);
            if (p < 0) t = -35'sd1 - t;
            if (t != 1) begin t = t >>> 1; s = s + 2'd1; end
            if (t != 1) begin s = s + 2'd1; end
            cn = 35'(p >>> (6'd15 + 6'(s)));
            ex = ex + 11'(s);
            if (cn == 0) ex = -11'sd128;
            if (ex > 11'sd127) begin
               s3_in.ov = 1'b1; ex = 11'sd127;
               cn = cn > 0 ? 35'sh0_FFFF_FFFF : -35'sh1_0000_0000;
            end else if (ex < -11'sd128) begin
               s3_in.uf = 1'b1; ex = -11'sd128; cn = '0;
            end
            s3_in.e = ex[7:0];
            s3_in.m = defa_pkg::pack_man(cn);
         end
         defa_pkg::CMD_NORM: begin
            if (m == 0) begin
               s3_in.e = 8'hff; s3_in.m = '0;
            end else begin
               n = defa_pkg::clz32(m[31] ? ~m : m);
               ex = ex - 11'(n);
               if (ex < -11'sd128) begin
                  s3_in.e = defa_pkg::EXP_ZERO; s3_in.m = '0; s3_in.uf = 1'b1;
               end else begin
                  s3_in.e = ex[7:0];
                  s3_in.m = (m << n) ^ 32'h8000_0000;
               end
            end
         end
         defa_pkg::CMD_RND: begin
            if (m == 0 && s2_ff.e == 10'(defa_pkg::EXP_ZERO)) begin
               s3_in.m = '0; s3_in.uf = 1'b1;
            end else begin
               rc = defa_pkg::mant33(m) + 35'sd128;
               if (rc >= 35'sh1_0000_0000) begin
                  rc = rc >>> 1;
                  if (ex + 11'sd1 > 11'sd127) begin
                     s3_in.ov = 1'b1; rc = 35'sh0_FFFF_FFFF;
                  end else ex = ex + 11'sd1;
               end
               s3_in.e = ex[7:0];
               s3_in.m = defa_pkg::pack_man(rc) & 32'hffff_ff00;
            end
         end
         defa_pkg::CMD_FLOAT: begin
            u = s2_ff.raw;
            if (u == 0) begin
               s3_in.e = defa_pkg::EXP_ZERO; s3_in.m = '0;
            end else begin
               n = defa_pkg::clz32(u[31] ? ~u : u);
               s3_in.e = 8'sd31 - 8'(n);
               s3_in.m = u[31] ? ((u << n) | 32'h8000_0000) : ((u << n) & 32'h7fff_ffff);
            end
         end
         defa_pkg::CMD_FIX: begin
            s3_in.e = '0;
            if (ex > 11'sd30) begin
               s3_in.ov = 1'b1;
               s3_in.m = m[31] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
               t = (11'sd31 - ex > 11'sd32) ? 35'sd32 : 35'(11'sd31 - ex);
               rc = defa_pkg::mant33(m) >>> t[5:0];
               s3_in.m = rc[31:0];
            end
         end
         defa_pkg::CMD_TOSGL: begin
            s3_in.e = '0;
            s3_in.m = {s2_ff.e[7:0], m[31:8]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_res_exp = s3_ff.e;
   assign rsp_res_man = s3_ff.m;
   assign rsp_overflow = s3_ff.ov;
   assign rsp_underflow = s3_ff.uf;
endmodule

[rtl/defa_expand.sv]
// operand expansion of short and single forms to extended form
module defa_expand (
   input  logic [1:0]  form,
   input  logic [7:0]  exp_in,
   input  logic [31:0] man_in,
   output logic signed [9:0] exp_out,
   output logic [31:0] man_out
);
   always_comb begin
      if (form == defa_pkg::FORM_SHORT) begin
         if (man_in[15:12] == 4'h8) begin
            exp_out = 10'(defa_pkg::EXP_ZERO);
            man_out = '0;
         end else begin
            exp_out = 10'(signed'(man_in[15:12]));
            man_out = {man_in[11:0], 20'd0};
         end
      end else if (form == defa_pkg::FORM_SINGLE) begin
         exp_out = 10'(signed'(man_in[31:24]));
         man_out = (man_in[31:24] == 8'h80) ? '0 : {man_in[23:0], 8'd0};
      end else begin
         exp_out = 10'(signed'(exp_in));
         man_out = man_in;
      end
   end
endmodule

[rtl/defa_checker.sv]
// port-level checker for the extended float alu, bound to the top level
module defa_checker (
   input logic clock, input logic reset,
   input logic req_valid, input logic req_stall,
   input logic rsp_valid, input logic rsp_stall,
   input logic [7:0] rsp_res_exp, input logic [31:0] rsp_res_man,
   input logic rsp_overflow, input logic rsp_underflow
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_man))
      else $error("stalled transaction changed");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_underflow))
      else $error("both flags set");
   a_uf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_underflow |-> rsp_res_man == 32'd0)
      else $error("underflow without flush");
   a_nostall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("transaction lost");
endmodule

bind dsp_extended_float_alu defa_checker u_defa_checker (.*);
